FILE: hdl/tsre_pkg.sv
`default_nettype none
package tsre_pkg;

  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_ACK   = 2'd1,
    OP_TICK  = 2'd2,
    OP_EMPTY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_NEW    = 2'd1,
    KIND_RETX   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ISN     = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_MSS     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] ack_number;
    logic [15:0] adv_window;
    logic [15:0] elapsed_ms;
    logic [15:0] bytes_buffered;
    logic        input_ended;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seqno;
    logic [10:0] payload_len;
    logic        syn;
    logic        fin;
    logic        ack_ok;
    logic [16:0] in_flight;
    logic [7:0]  retx_count;
    logic        last;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ACK_RD,
    ST_ACK_WAIT,
    ST_ACK_CHK,
    ST_FILL,
    ST_FILL_EMIT,
    ST_TICK,
    ST_TICK_RD,
    ST_TICK_WAIT,
    ST_TICK_EMIT,
    ST_STATUS
  } state_t;

  localparam int RoomLimit = 63;
  localparam logic [31:0] TimeoutMax = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

FILE: hdl/tsre_stream_if.sv
`default_nettype none
interface tsre_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/tsre_ram.sv
`default_nettype none
module tsre_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/tsre_front.sv
`default_nettype none
// Input queue: two-entry FIFO between the event port and the engine.
module tsre_front
  import tsre_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_data,
  output logic       q_valid,
  input  wire logic  q_pop,
  output item_t      q_data
);
  item_t      slot [2];
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       push;

  assign in_ready = cnt != 2'd2;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt != 2'd0;
  assign q_data   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= in_data;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop && q_valid) rptr <= ~rptr;
      cnt <= cnt + 2'(push) - 2'(q_pop && q_valid);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/tsre_back.sv
`default_nettype none
module tsre_back
  import tsre_pkg::*;
#(
  parameter int Depth = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire item_t       q_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output result_t          out_data
);
  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  logic [31:0] isn;
  logic [15:0] init_to;
  logic [10:0] mss;

  state_t state, state_next;
  item_t  it;
  logic   syn_sent, fin_sent, timer_running, ack_ok;
  logic [63:0] next_seq, acked_seq;
  logic [15:0] peer_win;
  logic [31:0] time_left, cur_to;
  logic [7:0]  retries;
  logic [16:0] flight;
  logic [AW-1:0] head, tail;
  logic [CW-1:0] count;
  logic [5:0]  nres;
  logic [15:0] avail;

  // ring memories
  logic        ring_we;
  logic [63:0] rs_rd;
  logic [12:0] ri_rd;
  logic [12:0] ri_wr;

  // fill step calc, registered in FILL, consumed in FILL_EMIT
  logic [10:0] f_take;
  logic        f_fin, f_syn, f_send, f_stop;

  // output register
  logic    ov;
  result_t od;
  logic    out_free;
  logic    emit;
  assign out_free  = !ov || out_ready;
  assign out_valid = ov;
  assign out_data  = od;
  assign emit = out_free && (state == ST_FILL_EMIT || state == ST_TICK_EMIT ||
                state == ST_STATUS ||
                (state == ST_DISPATCH && op_t'(it.opcode) == OP_EMPTY));

  tsre_ram #(.Width(64), .Depth(Depth)) u_seq_ram (
    .clk, .we(ring_we), .waddr(tail), .wdata(next_seq), .raddr(head), .rdata(rs_rd));
  tsre_ram #(.Width(13), .Depth(Depth)) u_info_ram (
    .clk, .we(ring_we), .waddr(tail), .wdata(ri_wr), .raddr(head), .rdata(ri_rd));

  // fill step combinational decision
  logic [63:0] used;
  logic [16:0] win, remain, size;
  logic [16:0] take;
  logic        c_send, c_fin, c_stop, c_syn;
  logic [10:0] info_len;
  logic [11:0] seg_len;
  logic [63:0] unw;
  logic [31:0] off;
  logic [63:0] base;

  always_comb begin
    win    = (peer_win == 16'd0) ? 17'd1 : {1'b0, peer_win};
    used   = next_seq - acked_seq;
    remain = (used >= {47'd0, win}) ? 17'd0 : win - used[16:0];
    size   = ({6'd0, mss} < remain) ? {6'd0, mss} : remain;
    take   = ({1'b0, avail} < size) ? {1'b0, avail} : size;
    c_syn  = 1'b0;
    c_fin  = 1'b0;
    c_send = 1'b0;
    c_stop = 1'b1;
    if (count < CW'(Depth) && nres < 6'(RoomLimit)) begin
      if (!syn_sent) begin
        c_syn  = 1'b1;
        c_send = 1'b1;
      end else if (!fin_sent && used < {47'd0, win}) begin
        if (it.input_ended && avail == take[15:0] && take < size) begin
          c_fin  = 1'b1;
          c_send = 1'b1;
        end else if (take != 17'd0) begin
          c_send = 1'b1;
          c_stop = 1'b0;
        end
      end
    end
    info_len = ri_rd[10:0];
    seg_len  = {1'b0, info_len} + 12'(ri_rd[11]) + 12'(ri_rd[12]);
    off  = it.ack_number - isn;
    base = {acked_seq[63:32], off};
    unw  = base;
    if (base > acked_seq && base - acked_seq > 64'h8000_0000 && base >= 64'h1_0000_0000)
      unw = base - 64'h1_0000_0000;
    else if (base < acked_seq && acked_seq - base > 64'h8000_0000)
      unw = base + 64'h1_0000_0000;
  end

  assign ri_wr   = {f_fin, f_syn, f_take};
  assign ring_we = state == ST_FILL_EMIT && f_send && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (q_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (op_t'(it.opcode))
          OP_FILL:  state_next = ST_FILL;
          OP_ACK:   state_next = ST_ACK_RD;
          OP_TICK:  state_next = ST_TICK;
          OP_EMPTY: state_next = out_free ? ST_STATUS : ST_DISPATCH;
        endcase
      end
      ST_ACK_RD: begin
        if (unw > next_seq || unw <= acked_seq) state_next = ST_STATUS;
        else state_next = ST_ACK_WAIT;
      end
      ST_ACK_WAIT:  state_next = ST_ACK_CHK;
      ST_ACK_CHK: begin
        if (count == '0 || acked_seq < rs_rd + 64'(seg_len)) state_next = ST_FILL;
        else state_next = ST_ACK_WAIT;
      end
      ST_FILL:      state_next = c_send ? ST_FILL_EMIT : ST_STATUS;
      ST_FILL_EMIT: if (out_free) state_next = f_stop ? ST_STATUS : ST_FILL;
      ST_TICK: begin
        if (count == '0 || !timer_running) state_next = ST_STATUS;
        else if (time_left <= {16'd0, it.elapsed_ms}) state_next = ST_TICK_RD;
        else state_next = ST_STATUS;
      end
      ST_TICK_RD:   state_next = ST_TICK_WAIT;
      ST_TICK_WAIT: state_next = ST_TICK_EMIT;
      ST_TICK_EMIT: if (out_free) state_next = ST_STATUS;
      ST_STATUS:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  assign q_pop = state == ST_IDLE && q_valid;

  always_ff @(posedge clk) begin
    if (q_pop) it <= q_data;
    if (state == ST_FILL) begin
      f_take <= c_syn ? 11'd0 : take[10:0];
      f_syn  <= c_syn;
      f_fin  <= c_fin;
      f_send <= c_send;
      f_stop <= c_stop;
    end
    if (rst) begin
      state <= ST_IDLE;
      ov <= 1'b0;
      isn <= '0;
      init_to <= 16'd1000;
      mss <= 11'd1000;
      syn_sent <= 1'b0;
      fin_sent <= 1'b0;
      next_seq <= '0;
      acked_seq <= '0;
      peer_win <= 16'd1;
      timer_running <= 1'b0;
      time_left <= 32'd1000;
      cur_to <= 32'd1000;
      retries <= '0;
      flight <= '0;
      head <= '0;
      tail <= '0;
      count <= '0;
      nres <= '0;
      ack_ok <= 1'b1;
      avail <= '0;
    end else begin
      state <= state_next;
      ov <= emit || (ov && !out_ready);
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ISN:     isn <= cfg_data;
          REG_TIMEOUT: begin
            init_to   <= cfg_data[15:0];
            cur_to    <= {16'd0, cfg_data[15:0]};
            time_left <= {16'd0, cfg_data[15:0]};
          end
          REG_MSS:     mss <= cfg_data[10:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          nres   <= '0;
          ack_ok <= 1'b1;
        end
        ST_DISPATCH: begin
          avail <= it.bytes_buffered;
          if (op_t'(it.opcode) == OP_EMPTY && out_free) begin
            od <= '{kind: KIND_EMPTY, seqno: next_seq[31:0] + isn, default: '0};
          end
        end
        ST_ACK_RD: begin
          peer_win <= it.adv_window;
          if (unw > next_seq) ack_ok <= 1'b0;
          else if (unw > acked_seq) acked_seq <= unw;
        end
        ST_ACK_WAIT: ;
        ST_ACK_CHK: begin
          if (count != '0 && !(acked_seq < rs_rd + 64'(seg_len))) begin
            flight    <= flight - 17'(seg_len);
            head      <= (head == AW'(Depth - 1)) ? '0 : head + 1'b1;
            count     <= count - 1'b1;
            retries   <= '0;
            cur_to    <= {16'd0, init_to};
            time_left <= {16'd0, init_to};
          end else begin
            timer_running <= flight != 17'd0;
          end
        end
        ST_FILL: ;
        ST_FILL_EMIT: begin
          if (out_free) begin
            od <= '{kind: KIND_NEW, seqno: next_seq[31:0] + isn, payload_len: f_take,
                    syn: f_syn, fin: f_fin, default: '0};
            next_seq <= next_seq + 64'(f_take) + 64'(f_syn) + 64'(f_fin);
            flight   <= flight + 17'(f_take) + 17'(f_syn) + 17'(f_fin);
            timer_running <= 1'b1;
            time_left <= cur_to;
            tail  <= (tail == AW'(Depth - 1)) ? '0 : tail + 1'b1;
            count <= count + 1'b1;
            nres  <= nres + 1'b1;
            avail <= avail - {5'd0, f_take};
            if (f_syn) syn_sent <= 1'b1;
            if (f_fin) fin_sent <= 1'b1;
          end
        end
        ST_TICK: begin
          if (count == '0) timer_running <= 1'b0;
          else if (timer_running) begin
            if (time_left <= {16'd0, it.elapsed_ms}) time_left <= '0;
            else time_left <= time_left - {16'd0, it.elapsed_ms};
          end
        end
        ST_TICK_RD, ST_TICK_WAIT: ;
        ST_TICK_EMIT: begin
          if (out_free) begin
            od <= '{kind: KIND_RETX, seqno: rs_rd[31:0] + isn, payload_len: ri_rd[10:0],
                    syn: ri_rd[11], fin: ri_rd[12], default: '0};
            if (peer_win != 16'd0) begin
              cur_to    <= cur_to[31] ? TimeoutMax : {cur_to[30:0], 1'b0};
              time_left <= cur_to[31] ? TimeoutMax : {cur_to[30:0], 1'b0};
              if (retries != 8'hFF) retries <= retries + 1'b1;
            end else begin
              time_left <= cur_to;
            end
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            od <= '{kind: KIND_STATUS, seqno: next_seq[31:0] + isn, ack_ok: ack_ok,
                    in_flight: flight, retx_count: retries, last: 1'b1, default: '0};
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/tcp_sender_retransmit_engine.sv
`default_nettype none
// TCP sender control engine.
// Channels: in_ch carries one event beat (fill, ack, tick, empty segment);
// out_ch carries result beats: zero or more segment descriptors, then one
// status beat with last = 1. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); the user writes it only while the engine is
// idle, which the engine does not enforce. A two-entry queue decouples event
// intake from the sequencer that walks the outstanding-segment ring (two RAMs,
// registered read). An empty-segment event emits its segment, then status; a
// tick may retransmit the oldest segment; an ack retires acknowledged segments,
// then fills; a fill produces segments while window, data and ring room allow.
// One event is processed at a time by the sequencer.
// Reset (rst, synchronous) restores control state and config; ring contents,
// held event and output data are not cleared. A stalled output holds its beat
// in the output register, the sequencer waits, and the queue accepts up to two.
module tcp_sender_retransmit_engine
  import tsre_pkg::*;
#(
  parameter int OUTSTANDING_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  tsre_stream_if.sink      in_ch,
  tsre_stream_if.source    out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic    q_valid, q_pop;
  item_t   q_data;

  tsre_front u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .q_valid, .q_pop, .q_data);

  tsre_back #(.Depth(OUTSTANDING_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data,
    .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule
`default_nettype wire

FILE: hdl/tsre_checker.sv
`default_nettype none
module tsre_checker
  import tsre_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire result_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.kind == KIND_STATUS)
    else $error("last on non-status beat");
  a_seg_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_STATUS |-> !out_data.last && out_data.retx_count == 8'd0)
    else $error("segment beat carries status fields");
endmodule

bind tcp_sender_retransmit_engine tsre_checker u_chk (
  .clk, .rst, .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
